FILE: rtl/hsoc_pkg.sv
package hsoc_pkg;

	localparam int WAYS = 8;
	localparam int SETS = 256;
	localparam int WAY_W = $clog2(WAYS);
	localparam int SET_W = $clog2(SETS);
	localparam int SLOT_W = WAY_W + SET_W;
	localparam int MASK_W = 8;
	localparam int CHG_W = 33;

	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	localparam logic [1:0] CMD_FIND    = 2'd0;
	localparam logic [1:0] CMD_FILL    = 2'd1;
	localparam logic [1:0] CMD_PUBLISH = 2'd2;
	localparam logic [1:0] CMD_REMOVE  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_BUDGET   = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_BAD_ID   = 3'd5;

	localparam int REG_W = 2;
	localparam logic [REG_W-1:0] REG_BUDGET   = 2'd0;
	localparam logic [REG_W-1:0] REG_MASK     = 2'd1;
	localparam logic [REG_W-1:0] REG_OVERHEAD = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] obj_key;
		logic [63:0] sequence_req;
		logic [63:0] spatial_key;
		logic [31:0] document_ref;
		logic [31:0] doc_len;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] found_sequence;
		logic [63:0] found_spatial_key;
		logic [31:0] found_document_ref;
		logic [31:0] found_doc_len;
		logic [31:0] bytes_in_use;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic hash_step;
		logic scan_start;
		logic scan_step;
		logic finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad_id;
		logic scan_last;
		logic hash_last;
		logic clearing;
	} dp_sts_t;

endpackage

FILE: rtl/hsoc_stream_if.sv
interface hsoc_req_if;
	import hsoc_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface hsoc_rsp_if;
	import hsoc_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/hsoc_ctrl.sv
module hsoc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output hsoc_pkg::dp_cmd_t cmd,
	input  hsoc_pkg::dp_sts_t sts
);
	import hsoc_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HASH = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;

	// accept only when idle and the valid store is cleared; commit waits for the output register
	assign in_ready = (state_q == S_IDLE) && !sts.clearing;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !sts.clearing) begin
					cmd.load = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last) begin
					cmd.scan_start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.bad_id) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
					if (sts.scan_last) state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/hsoc_datapath.sv
module hsoc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  hsoc_pkg::dp_cmd_t cmd,
	output hsoc_pkg::dp_sts_t sts,
	input  hsoc_pkg::req_t    req,
	output hsoc_pkg::rsp_t    rsp,
	input  logic [31:0]       byte_budget,
	input  logic [7:0]        set_index_mask,
	input  logic [7:0]        entry_overhead_bytes
);
	import hsoc_pkg::*;

	localparam logic [2:0] HASH_LAST = 3'd6;

	// slot store: valid bits one word per set, cleared by a pass after reset; payload in memories
	logic [WAYS-1:0] valid_mem [SETS];
	logic [63:0] key_mem [SETS*WAYS];
	logic [63:0] ver_mem [SETS*WAYS];
	logic [63:0] spc_mem [SETS*WAYS];
	logic [31:0] ref_mem [SETS*WAYS];
	logic [31:0] len_mem [SETS*WAYS];
	logic [CHG_W-1:0] chg_mem [SETS*WAYS];

	req_t        req_q;
	logic [63:0] h_q;
	logic [63:0] acc_q;
	logic [2:0]  hphase_q;
	logic [31:0] used_q;
	rsp_t        rsp_q;

	logic             clearing_q;
	logic [SET_W-1:0] clr_idx_q;

	logic [SET_W-1:0] set_q;
	logic [WAY_W:0]   way_q;      // read address counter, one past per step
	logic [WAY_W:0]   rway_q;     // way whose data is in the read registers
	logic             rvalid_q;
	logic [WAYS-1:0]  vset_q;

	// registered read data
	logic [63:0] rd_key_q, rd_ver_q, rd_spc_q;
	logic [31:0] rd_ref_q, rd_len_q;
	logic [CHG_W-1:0] rd_chg_q;

	// scan results
	logic          hit_q;
	logic          stop_q;
	logic [WAY_W:0] target_q;
	logic [CHG_W+WAY_W:0] recl_q;
	logic [2:0]    fill_st_q;
	logic [63:0]   f_ver_q, f_spc_q;
	logic [31:0]   f_ref_q, f_len_q;

	logic [CHG_W-1:0] charge;
	assign charge = {25'd0, entry_overhead_bytes} + {1'b0, req_q.doc_len};

	// hash: xor-shift steps and 64-bit multiplies built from three 32x32 partial products
	logic [63:0] mix_c;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [63:0] hsum;
	logic [63:0] hx, acc_d;
	always_comb begin
		mix_c = (hphase_q < 3'd4) ? MIX_C1 : MIX_C2;
		mul_a = h_q[31:0];
		mul_b = mix_c[31:0];
		if (hphase_q == 3'd2 || hphase_q == 3'd5) mul_a = h_q[63:32];
		if (hphase_q == 3'd3 || hphase_q == HASH_LAST) mul_b = mix_c[63:32];
		// one shared 32x32 multiplier
		prod = {32'd0, mul_a} * {32'd0, mul_b};
		hsum = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
		hx = h_q;
		acc_d = acc_q;
		case (hphase_q) inside
			3'd0: hx = h_q ^ (h_q >> 30);
			3'd1, 3'd4: acc_d = prod;
			3'd2, 3'd5: acc_d = hsum;
			3'd3: hx = hsum ^ (hsum >> 27);
			default: hx = hsum ^ (hsum >> 31);
		endcase
	end

	logic [SET_W-1:0] set_idx;
	assign set_idx = SET_W'(hx[MASK_W-1:0] & set_index_mask);

	logic [SLOT_W-1:0] raddr;
	assign raddr = {set_q, way_q[WAY_W-1:0]};

	assign sts.bad_id = (req_q.obj_key == 64'd0);
	assign sts.scan_last = (rway_q == (WAY_W+1)'(WAYS-1)) && rvalid_q;
	assign sts.hash_last = (hphase_q == HASH_LAST);
	assign sts.clearing = clearing_q;

	// evaluate the way in the read registers
	logic cur_v, cur_match;
	assign cur_v = vset_q[rway_q[WAY_W-1:0]];
	assign cur_match = cur_v && (rd_key_q == req_q.obj_key);

	// write port
	logic we;
	logic [SLOT_W-1:0] waddr;

	// final outcome computation
	logic [32:0] used_ext, budget_ext, avail;
	logic [CHG_W+WAY_W:0] recl_fin;
	logic [WAY_W-1:0] pub_tgt;
	logic pub_evict;
	logic fill_ok;
	logic [32:0] fill_sum;

	always_comb begin
		used_ext = {1'b0, used_q};
		budget_ext = {1'b0, byte_budget};
		pub_evict = (target_q == (WAY_W+1)'(WAYS));
		pub_tgt = pub_evict ? h_q[32 +: WAY_W] : target_q[WAY_W-1:0];
		recl_fin = recl_q;
		if (pub_evict && vset_q[pub_tgt])
			recl_fin = recl_q + (CHG_W+WAY_W+1)'(rd_chg_q);
		if (used_ext <= budget_ext && recl_fin <= (CHG_W+WAY_W+1)'(used_ext))
			avail = budget_ext - used_ext + recl_fin[32:0];
		else
			avail = 33'd0;
		fill_ok = (used_ext <= budget_ext) && (charge <= budget_ext - used_ext);
		fill_sum = used_ext + charge;
	end

	// the last scan step reads the eviction candidate; hold read data between steps
	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_key_q <= key_mem[raddr];
			rd_ver_q <= ver_mem[raddr];
			rd_spc_q <= spc_mem[raddr];
			rd_ref_q <= ref_mem[raddr];
			rd_len_q <= len_mem[raddr];
			rd_chg_q <= chg_mem[raddr];
		end
		if (we) begin
			key_mem[waddr] <= req_q.obj_key;
			ver_mem[waddr] <= req_q.sequence_req;
			spc_mem[waddr] <= req_q.spatial_key;
			ref_mem[waddr] <= req_q.document_ref;
			len_mem[waddr] <= req_q.doc_len;
			chg_mem[waddr] <= charge;
		end
	end

	// commit logic on finish
	logic [2:0]  st_d;
	logic [31:0] used_d;
	logic [WAYS-1:0] vset_d;
	always_comb begin
		st_d = ST_OK;
		used_d = used_q;
		vset_d = vset_q;
		we = 1'b0;
		waddr = {set_q, pub_tgt};
		if (sts.bad_id) begin
			st_d = ST_BAD_ID;
		end else begin
			case (req_q.command)
				CMD_FIND: st_d = hit_q ? ST_OK : ST_MISS;
				CMD_FILL: begin
					if (!fill_ok) st_d = ST_BUDGET;
					else begin
						st_d = fill_st_q;
						if (fill_st_q == ST_OK) begin
							used_d = fill_sum[31:0];
							we = 1'b1;
							waddr = {set_q, target_q[WAY_W-1:0]};
							vset_d[target_q[WAY_W-1:0]] = 1'b1;
						end
					end
				end
				CMD_PUBLISH: begin
					vset_d[pub_tgt] = 1'b0;
					if (charge > avail) begin
						st_d = ST_BUDGET;
						used_d = (recl_fin >= (CHG_W+WAY_W+1)'(used_q)) ? 32'd0 :
							used_q - recl_fin[31:0];
					end else begin
						we = 1'b1;
						vset_d[pub_tgt] = 1'b1;
						used_d = used_q - recl_fin[31:0] + charge[31:0];
					end
				end
				default: begin
					st_d = hit_q ? ST_OK : ST_MISS;
					used_d = (recl_q >= (CHG_W+WAY_W+1)'(used_q)) ? 32'd0 :
						used_q - recl_q[31:0];
				end
			endcase
		end
		we = we && cmd.finish;
	end

	// valid store: clearing pass after reset, then one set word per commit with a nonzero id
	always_ff @(posedge clk) begin
		if (clearing_q) valid_mem[clr_idx_q] <= '0;
		else if (cmd.finish && !sts.bad_id) valid_mem[set_q] <= vset_d;
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q <= '0;
			used_q <= 32'd0;
			hphase_q <= 3'd0;
			rvalid_q <= 1'b0;
			way_q <= '0;
			rway_q <= '0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == SET_W'(SETS-1)) clearing_q <= 1'b0;
			end
			if (cmd.load) begin
				h_q <= req.obj_key;
				hphase_q <= 3'd0;
				req_q <= req;
			end
			if (cmd.hash_step) begin
				h_q <= hx;
				acc_q <= acc_d;
				hphase_q <= hphase_q + 3'd1;
			end
			if (cmd.scan_start) begin
				// hash complete on this edge: set from next value
				set_q <= set_idx;
				vset_q <= valid_mem[set_idx];
				way_q <= '0;
				rvalid_q <= 1'b0;
				hit_q <= 1'b0;
				stop_q <= 1'b0;
				target_q <= (WAY_W+1)'(WAYS);
				recl_q <= '0;
				fill_st_q <= ST_FULL;
				f_ver_q <= '0; f_spc_q <= '0; f_ref_q <= '0; f_len_q <= '0;
			end
			if (cmd.scan_step) begin
				rway_q <= way_q;
				rvalid_q <= 1'b1;
				if (way_q != (WAY_W+1)'(WAYS - 1)) way_q <= way_q + 1'b1;
				else way_q <= {1'b0, h_q[32 +: WAY_W]};
				if (rvalid_q) begin
					if (cur_match) begin
						if (!hit_q) begin
							f_ver_q <= rd_ver_q; f_spc_q <= rd_spc_q;
							f_ref_q <= rd_ref_q; f_len_q <= rd_len_q;
						end
						hit_q <= 1'b1;
						if (req_q.command == CMD_PUBLISH || req_q.command == CMD_REMOVE) begin
							recl_q <= recl_q + (CHG_W+WAY_W+1)'(rd_chg_q);
							vset_q[rway_q[WAY_W-1:0]] <= 1'b0;
						end
					end
					if ((cur_match || !cur_v) && target_q == (WAY_W+1)'(WAYS))
						target_q <= rway_q;
					if (!stop_q && (cur_match || !cur_v)) begin
						stop_q <= 1'b1;
						fill_st_q <= cur_match ? ST_DUP : ST_OK;
					end
				end
			end
			if (cmd.finish) begin
				used_q <= used_d;
				rsp_q.status <= st_d;
				rsp_q.bytes_in_use <= used_d;
				if (!sts.bad_id && req_q.command == CMD_FIND && hit_q) begin
					rsp_q.found_sequence <= f_ver_q;
					rsp_q.found_spatial_key <= f_spc_q;
					rsp_q.found_document_ref <= f_ref_q;
					rsp_q.found_doc_len <= f_len_q;
				end else begin
					rsp_q.found_sequence <= '0;
					rsp_q.found_spatial_key <= '0;
					rsp_q.found_document_ref <= '0;
					rsp_q.found_doc_len <= '0;
				end
			end
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: rtl/hashed_set_assoc_object_cache_unit.sv
// Hashed set-associative object cache (8 ways x 256 sets).
// Channels: req (sink) carries command, key and entry data; rsp (source)
// returns one result per request with status, hit data and bytes in use.
// Configuration: APB port, registers byte_budget (0x0), set_index_mask (0x4),
// entry_overhead_bytes (0x8); write them only while no request is in flight.
// After a request transfers, the block hashes the key (each 64-bit multiply
// is three 32x32 partial products on one shared multiplier), scans the ways
// through the registered read port of the slot memory (eight ways plus the
// eviction candidate), then commits the result to the output register.
// A new request is taken only in the idle state after the previous one
// commits, so the block works on one request at a time.
// Reset zeroes bytes in use and returns the registers to their reset values,
// then a clearing pass over all 256 sets empties the valid bits one set per
// cycle; req stays not ready until it ends. A stalled rsp holds its result;
// the block waits in its commit state until the output register is free.
module hashed_set_assoc_object_cache_unit (
	input  logic        clk,
	input  logic        arst_n,
	hsoc_req_if.sink    req,
	hsoc_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hsoc_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t dsts;
	logic [31:0] budget_q;
	logic [7:0]  mask_q, ovh_q;
	logic [REG_W-1:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= 32'd1048576;
			mask_q <= 8'd255;
			ovh_q <= 8'd40;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_BUDGET:   budget_q <= pwdata;
				REG_MASK:     mask_q <= pwdata[7:0];
				REG_OVERHEAD: ovh_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (ridx)
			REG_BUDGET:   prdata = budget_q;
			REG_MASK:     prdata = {24'd0, mask_q};
			REG_OVERHEAD: prdata = {24'd0, ovh_q};
			default:      prdata = 32'd0;
		endcase
	end

	hsoc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(dcmd), .sts(dsts)
	);

	hsoc_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(dcmd), .sts(dsts),
		.req(req.payload), .rsp(rsp.payload),
		.byte_budget(budget_q), .set_index_mask(mask_q),
		.entry_overhead_bytes(ovh_q)
	);

endmodule

FILE: rtl/hsoc_checker.sv
module hsoc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [31:0] rsp_bytes
);
	import hsoc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("stalled response changed");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= ST_BAD_ID)
		else $error("status out of range");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while busy");
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_BAD_ID && !rsp_ready |=> $stable(rsp_bytes))
		else $error("bytes changed on invalid id");
endmodule

bind hashed_set_assoc_object_cache_unit hsoc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_status(rsp.payload.status), .rsp_bytes(rsp.payload.bytes_in_use)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hsoc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hsoc_req_if req_ch ();
	hsoc_rsp_if rsp_ch ();

	hashed_set_assoc_object_cache_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	localparam int SLOTS = WAYS * SETS;
	localparam int LATENCY = 20;

	// shadow copy of the cache contents and registers
	logic        way_valid [SLOTS];
	logic [63:0] way_key [SLOTS];
	logic [63:0] way_seq [SLOTS];
	logic [63:0] way_morton [SLOTS];
	logic [31:0] way_doc_ref [SLOTS];
	logic [31:0] way_doc_size [SLOTS];
	logic [63:0] way_cost [SLOTS];
	logic [31:0] shadow_used;
	logic [31:0] shadow_budget;
	logic [7:0]  shadow_mask;
	logic [7:0]  shadow_overhead;

	rsp_t pending_results [$];
	int   errors;
	int   items_sent;
	int   results_seen;
	int   status_count [8];
	logic idle_on;
	int   rsp_hold_cycles;
	logic [63:0] id_pool [32];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("timeout at %0t", $time);
		$display("status: fail");
		$finish;
	end

	function automatic logic [63:0] mix64(logic [63:0] v);
		v = v ^ (v >> 30);
		v = v * 64'hbf58476d1ce4e5b9;
		v = v ^ (v >> 27);
		v = v * 64'h94d049bb133111eb;
		return v ^ (v >> 31);
	endfunction

	function automatic void release_bytes(logic [63:0] amount);
		if (amount >= {32'd0, shadow_used})
			shadow_used = '0;
		else
			shadow_used = shadow_used - amount[31:0];
	endfunction

	function automatic void store_way(int s, req_t r, logic [63:0] cost);
		way_valid[s]    = 1'b1;
		way_key[s]      = r.obj_key;
		way_seq[s]      = r.sequence_req;
		way_morton[s]   = r.spatial_key;
		way_doc_ref[s]  = r.document_ref;
		way_doc_size[s] = r.doc_len;
		way_cost[s]     = cost;
	endfunction

	// compute the result of one command and update the shadow state
	function automatic rsp_t cache_lookup(req_t r);
		rsp_t        o;
		logic [63:0] h;
		logic [63:0] cost;
		logic [63:0] budget;
		logic [63:0] used;
		logic [63:0] reclaimed;
		logic [63:0] avail;
		int          base;
		int          target;
		int          s;
		o = '0;
		cost = {56'd0, shadow_overhead} + {32'd0, r.doc_len};
		budget = {32'd0, shadow_budget};
		if (r.obj_key == '0) begin
			o.status = ST_BAD_ID;
		end else begin
			h = mix64(r.obj_key);
			base = int'((h & {56'd0, shadow_mask}) % SETS) * WAYS;
			case (r.command)
				CMD_FIND: begin
					o.status = ST_MISS;
					for (int w = 0; w < WAYS; w++) begin
						s = base + w;
						if (way_valid[s] && way_key[s] == r.obj_key) begin
							o.status = ST_OK;
							o.found_sequence = way_seq[s];
							o.found_spatial_key = way_morton[s];
							o.found_document_ref = way_doc_ref[s];
							o.found_doc_len = way_doc_size[s];
							break;
						end
					end
				end
				CMD_FILL: begin
					used = {32'd0, shadow_used};
					if (used > budget || cost > budget - used) begin
						o.status = ST_BUDGET;
					end else begin
						shadow_used = 32'(used + cost);
						o.status = ST_FULL;
						for (int w = 0; w < WAYS; w++) begin
							s = base + w;
							if (way_valid[s] && way_key[s] == r.obj_key) begin
								o.status = ST_DUP;
								break;
							end
							if (!way_valid[s]) begin
								store_way(s, r, cost);
								o.status = ST_OK;
								break;
							end
						end
						if (o.status != ST_OK)
							release_bytes(cost);
					end
				end
				CMD_PUBLISH: begin
					target = WAYS;
					reclaimed = '0;
					for (int w = 0; w < WAYS; w++) begin
						s = base + w;
						if (way_valid[s] && way_key[s] == r.obj_key) begin
							way_valid[s] = 1'b0;
							reclaimed = reclaimed + way_cost[s];
							if (target == WAYS)
								target = w;
						end else if (!way_valid[s] && target == WAYS) begin
							target = w;
						end
					end
					if (target == WAYS) begin
						target = int'((h >> 32) % WAYS);
						if (way_valid[base + target])
							reclaimed = reclaimed + way_cost[base + target];
						way_valid[base + target] = 1'b0;
					end
					used = {32'd0, shadow_used};
					avail = (used <= budget && reclaimed <= used) ? budget - used + reclaimed : '0;
					if (cost > avail) begin
						release_bytes(reclaimed);
						o.status = ST_BUDGET;
					end else begin
						store_way(base + target, r, cost);
						shadow_used = 32'(used - reclaimed + cost);
						o.status = ST_OK;
					end
				end
				default: begin
					o.status = ST_MISS;
					for (int w = 0; w < WAYS; w++) begin
						s = base + w;
						if (way_valid[s] && way_key[s] == r.obj_key) begin
							way_valid[s] = 1'b0;
							release_bytes(way_cost[s]);
							o.status = ST_OK;
						end
					end
				end
			endcase
		end
		o.bytes_in_use = shadow_used;
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t make_cmd(logic [1:0] cmd, logic [63:0] id, logic [31:0] size);
		req_t r;
		r.command = cmd;
		r.obj_key = id;
		r.sequence_req = rand64();
		r.spatial_key = rand64();
		r.document_ref = $urandom;
		r.doc_len = size;
		return r;
	endfunction

	// offer one command, hold it until the transfer, then record the expectation
	task automatic send_cmd(req_t r);
		if (idle_on && $urandom_range(99) < 38) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.payload = r;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(cache_lookup(r));
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	// two-phase register write, only with the block idle
	task automatic write_reg(logic [REG_W-1:0] idx, logic [31:0] value);
		wait_idle();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_BUDGET: shadow_budget = value;
			REG_MASK: shadow_mask = value[7:0];
			default: shadow_overhead = value[7:0];
		endcase
	endtask

	task automatic configure(logic [31:0] budget, logic [7:0] mask, logic [7:0] overhead);
		write_reg(REG_BUDGET, budget);
		write_reg(REG_MASK, {24'd0, mask});
		write_reg(REG_OVERHEAD, {24'd0, overhead});
	endtask

	// response side: random idling plus an optional long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_hold_cycles--;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = !(idle_on && $urandom_range(99) < 38);
			end
		end
	end

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// compare each transfer against the oldest expectation
	always @(posedge clk) begin
		rsp_t e;
		rsp_t a;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			a = rsp_ch.payload;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result, status %0d", $time, a.status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("status", e.status, a.status);
				check_field("found_sequence", e.found_sequence, a.found_sequence);
				check_field("found_spatial_key", e.found_spatial_key, a.found_spatial_key);
				check_field("found_document_ref", e.found_document_ref, a.found_document_ref);
				check_field("found_doc_len", e.found_doc_len, a.found_doc_len);
				check_field("bytes_in_use", e.bytes_in_use, a.bytes_in_use);
				status_count[e.status]++;
			end
			results_seen++;
		end
	end

	task automatic test_invalid_id();
		for (int c = 0; c < 4; c++)
			send_cmd(make_cmd(2'(c), '0, 32'd10));
	endtask

	// single set in use: fill it, overflow it, then evict and replace
	task automatic test_full_set();
		configure(32'hFFFF_FFFF, 8'd0, 8'd0);
		for (int i = 0; i < WAYS + 1; i++)
			send_cmd(make_cmd(CMD_FILL, id_pool[i], 32'd100 + i));
		send_cmd(make_cmd(CMD_FILL, id_pool[2], 32'd5));
		send_cmd(make_cmd(CMD_FIND, id_pool[3], 32'd0));
		send_cmd(make_cmd(CMD_FIND, id_pool[WAYS], 32'd0));
		send_cmd(make_cmd(CMD_PUBLISH, id_pool[WAYS + 1], 32'hFFFF_FFFF));
		send_cmd(make_cmd(CMD_PUBLISH, id_pool[4], 32'd7));
		send_cmd(make_cmd(CMD_FIND, id_pool[4], 32'd0));
		send_cmd(make_cmd(CMD_REMOVE, id_pool[5], 32'd0));
		send_cmd(make_cmd(CMD_REMOVE, id_pool[5], 32'd0));
	endtask

	task automatic test_budget_edges();
		configure(32'd300, 8'd255, 8'd255);
		send_cmd(make_cmd(CMD_FILL, id_pool[10], 32'd46));
		send_cmd(make_cmd(CMD_FILL, id_pool[11], 32'd0));
		send_cmd(make_cmd(CMD_PUBLISH, id_pool[12], 32'hFFFF_FFFF));
		configure(32'd0, 8'd255, 8'd0);
		send_cmd(make_cmd(CMD_FILL, id_pool[13], 32'd0));
		send_cmd(make_cmd(CMD_PUBLISH, id_pool[14], 32'd1));
		send_cmd(make_cmd(CMD_REMOVE, id_pool[10], 32'd0));
	endtask

	function automatic req_t random_cmd();
		logic [63:0] id;
		logic [31:0] size;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 3)
			id = '0;
		else if (pick < 10)
			id = rand64();
		else
			id = id_pool[$urandom_range(31)];
		size = ($urandom_range(9) == 0) ? $urandom : $urandom_range(5000);
		return make_cmd(2'($urandom_range(3)), id, size);
	endfunction

	// hold off the response side while commands keep coming
	task automatic test_backpressure();
		rsp_hold_cycles = 400;
		for (int i = 0; i < 20; i++)
			send_cmd(random_cmd());
		wait_idle();
	endtask

	task automatic test_random_phases();
		logic [31:0] budgets [6];
		logic [7:0]  masks [6];
		logic [7:0]  overheads [6];
		budgets = '{32'hFFFF_FFFF, 32'd20000, 32'd1048576, 32'd3000, 32'd0, 32'd60000};
		masks = '{8'd0, 8'd3, 8'd255, 8'd1, 8'd7, 8'd255};
		overheads = '{8'd255, 8'd0, 8'd40, 8'd17, 8'd255, 8'd128};
		for (int p = 0; p < 6; p++) begin
			configure(budgets[p], masks[p], overheads[p]);
			idle_on = (p != 2);
			for (int i = 0; i < 200; i++)
				send_cmd(random_cmd());
		end
		idle_on = 1'b1;
	endtask

	initial begin
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		rsp_hold_cycles = 0;
		idle_on = 1'b1;
		for (int i = 0; i < 8; i++)
			status_count[i] = 0;
		for (int i = 0; i < 32; i++)
			id_pool[i] = rand64() | 64'd1;
		for (int i = 0; i < SLOTS; i++) begin
			way_valid[i] = 1'b0;
			way_cost[i] = '0;
		end
		shadow_used = '0;
		shadow_budget = 32'd1048576;
		shadow_mask = 8'd255;
		shadow_overhead = 8'd40;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_invalid_id();
		test_full_set();
		test_budget_edges();
		test_backpressure();
		test_random_phases();

		wait_idle();
		$display("sent %0d commands, checked %0d results over six register settings",
			items_sent, results_seen);
		$display("statuses ok %0d miss %0d dup %0d budget %0d full %0d bad id %0d",
			status_count[0], status_count[1], status_count[2], status_count[3],
			status_count[4], status_count[5]);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
